// ===== rtl/core/pipo_pkg.sv =====
package pipo_pkg;

    typedef logic [7:0][7:0] state_t;

    typedef struct packed {
        logic valid;
        logic op;
    } ctl_t;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    localparam int KIND_ENTRY = 0;
    localparam int KIND_ROUND = 1;
    localparam int KIND_EXIT  = 2;

    localparam logic [7:0][2:0] ROT_FWD = {3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0};
    localparam logic [7:0][2:0] ROT_INV = {3'd6, 3'd7, 3'd3, 3'd2, 3'd5, 3'd4, 3'd1, 3'd0};

    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] d;
        d = {v, v} << n;
        return d[15:8];
    endfunction

    function automatic state_t rotate_fwd(input state_t x);
        state_t y;
        for (int k = 0; k < 8; k++)
        begin
            y[k] = rotl8(x[k], ROT_FWD[k]);
        end
        return y;
    endfunction

    function automatic state_t rotate_inv(input state_t x);
        state_t y;
        for (int k = 0; k < 8; k++)
        begin
            y[k] = rotl8(x[k], ROT_INV[k]);
        end
        return y;
    endfunction

    function automatic logic [63:0] round_subkey(input logic [7:0] r, input logic [63:0] kl,
                                                 input logic [63:0] kh);
        logic [63:0] base;
        base = r[0] ? kh : kl;
        return base ^ {56'd0, r};
    endfunction

    function automatic state_t sub_layer(input state_t xi);
        state_t x;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        x = xi;
        x[5] = x[5] ^ (x[7] & x[6]);
        x[4] = x[4] ^ (x[3] & x[5]);
        x[7] = x[7] ^ x[4];
        x[6] = x[6] ^ x[3];
        x[3] = x[3] ^ (x[4] | x[5]);
        x[5] = x[5] ^ x[7];
        x[4] = x[4] ^ (x[5] & x[6]);
        x[2] = x[2] ^ (x[1] & x[0]);
        x[0] = x[0] ^ (x[2] | x[1]);
        x[1] = x[1] ^ (x[2] | x[0]);
        x[2] = ~x[2];
        x[7] = x[7] ^ x[1];
        x[3] = x[3] ^ x[2];
        x[4] = x[4] ^ x[0];
        a = x[7];
        b = x[3];
        c = x[4];
        x[6] = x[6] ^ (a & x[5]);
        a = a ^ x[6];
        x[6] = x[6] ^ (c | b);
        b = b ^ x[5];
        x[5] = x[5] ^ (x[6] | c);
        c = c ^ (b & a);
        x[2] = x[2] ^ a;
        a = x[1] ^ c;
        x[1] = x[0] ^ b;
        x[0] = x[7];
        x[7] = a;
        b = x[3];
        x[3] = x[6];
        x[6] = b;
        c = x[4];
        x[4] = x[5];
        x[5] = c;
        return x;
    endfunction

    function automatic state_t inv_sub_layer(input state_t xi);
        state_t x;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        x = xi;
        a = x[7];
        x[7] = x[0];
        x[0] = x[1];
        x[1] = a;
        a = x[7];
        b = x[6];
        c = x[5];
        x[4] = x[4] ^ (x[3] | c);
        x[3] = x[3] ^ (c | b);
        b = b ^ x[4];
        a = a ^ x[3];
        c = c ^ (b & a);
        x[3] = x[3] ^ (x[4] & x[7]);
        x[0] = x[0] ^ b;
        x[1] = x[1] ^ c;
        x[2] = x[2] ^ a;
        a = x[3];
        x[3] = x[6];
        x[6] = a;
        a = x[5];
        x[5] = x[4];
        x[4] = a;
        x[7] = x[7] ^ x[1];
        x[3] = x[3] ^ x[2];
        x[4] = x[4] ^ x[0];
        x[4] = x[4] ^ (x[5] & x[6]);
        x[5] = x[5] ^ x[7];
        x[3] = x[3] ^ (x[4] | x[5]);
        x[6] = x[6] ^ x[3];
        x[7] = x[7] ^ x[4];
        x[4] = x[4] ^ (x[3] & x[5]);
        x[5] = x[5] ^ (x[7] & x[6]);
        x[2] = ~x[2];
        x[1] = x[1] ^ (x[2] | x[0]);
        x[0] = x[0] ^ (x[2] | x[1]);
        x[2] = x[2] ^ (x[1] & x[0]);
        return x;
    endfunction

endpackage

// ===== rtl/core/pipo_stage.sv =====
module pipo_stage #(
    parameter int ROUNDS = 13,
    parameter int KIND   = 1,
    parameter int RND    = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pipo_pkg::ctl_t     up_ctl,
    input  pipo_pkg::state_t   up_data,
    output logic               up_ready,
    output pipo_pkg::ctl_t     dn_ctl,
    output pipo_pkg::state_t   dn_data,
    input  logic               dn_ready,
    input  logic [63:0]        key_low,
    input  logic [63:0]        key_high
);

    localparam logic [7:0] ENC_RC  = 8'(RND);
    localparam logic [7:0] DEC_RC  = 8'(ROUNDS + 1 - RND);
    localparam logic [7:0] ZERO_RC = 8'd0;

    pipo_pkg::ctl_t   ctl_reg;
    pipo_pkg::state_t data_reg;
    pipo_pkg::state_t data_next;
    logic [63:0]      rk_zero;
    logic [63:0]      rk_enc;
    logic [63:0]      rk_dec;

    assign rk_zero = pipo_pkg::round_subkey(ZERO_RC, key_low, key_high);
    assign rk_enc  = pipo_pkg::round_subkey(ENC_RC, key_low, key_high);
    assign rk_dec  = pipo_pkg::round_subkey(DEC_RC, key_low, key_high);

    always_comb
    begin
        data_next = up_data;
        case (KIND)
            pipo_pkg::KIND_ENTRY:
            begin
                if (up_ctl.op == pipo_pkg::OP_ENCRYPT)
                begin
                    data_next = up_data ^ rk_zero;
                end
            end
            pipo_pkg::KIND_ROUND:
            begin
                if (up_ctl.op == pipo_pkg::OP_ENCRYPT)
                begin
                    data_next = pipo_pkg::rotate_fwd(pipo_pkg::sub_layer(up_data)) ^ rk_enc;
                end
                else
                begin
                    data_next = pipo_pkg::inv_sub_layer(pipo_pkg::rotate_inv(up_data ^ rk_dec));
                end
            end
            pipo_pkg::KIND_EXIT:
            begin
                if (up_ctl.op == pipo_pkg::OP_DECRYPT)
                begin
                    data_next = up_data ^ rk_zero;
                end
            end
            default:
            begin
                data_next = up_data;
            end
        endcase
    end

    assign up_ready = !ctl_reg.valid || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (up_ready)
        begin
            ctl_reg <= up_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_ctl  = ctl_reg;
    assign dn_data = data_reg;

endmodule

// ===== rtl/core/pipo64_128_block_cipher_unit.sv =====
// Channel   Handshake              Payload              Width
// cmd       cmd_valid/cmd_ready    opcode, block_in     1 + 64
// rsp       rsp_valid/rsp_ready    block_out            64
// cfg       cfg_we                 cfg_index, cfg_data  1 + 64
//
// Each request passes through ROUNDS + 2 register stages: a key add used only to encrypt,
// one stage per round, and a final key add used only to decrypt. A new request is taken
// every cycle unless the response stalls; the round stage with its S-box sets the clock.
// Reset clears the stage valid bits and both key registers to zero.
// A stalled response holds its stage, and each stage upstream stops only once it is full.
module pipo64_128_block_cipher_unit #(
    parameter int ROUNDS = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic        opcode,
    input  logic [63:0] block_in,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [63:0] block_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int NSTAGE = ROUNDS + 2;

    logic [63:0]      key_low_reg;
    logic [63:0]      key_high_reg;
    pipo_pkg::ctl_t   ctl_s   [0:NSTAGE];
    pipo_pkg::state_t data_s  [0:NSTAGE];
    logic             ready_s [0:NSTAGE];
    logic [NSTAGE-1:0] stage_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pipo_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                pipo_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                default:                key_low_reg  <= key_low_reg;
            endcase
        end
    end

    assign ctl_s[0].valid = cmd_valid;
    assign ctl_s[0].op    = opcode;
    assign data_s[0]      = block_in;
    assign cmd_ready      = ready_s[0];
    assign ready_s[NSTAGE] = rsp_ready;

    genvar i;
    generate
        for (i = 0; i < NSTAGE; i++)
        begin : g_stage
            localparam int KIND = (i == 0) ? pipo_pkg::KIND_ENTRY :
                                  (i == NSTAGE - 1) ? pipo_pkg::KIND_EXIT :
                                  pipo_pkg::KIND_ROUND;

            pipo_stage #(
                .ROUNDS (ROUNDS),
                .KIND   (KIND),
                .RND    (i)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_ctl   (ctl_s[i]),
                .up_data  (data_s[i]),
                .up_ready (ready_s[i]),
                .dn_ctl   (ctl_s[i+1]),
                .dn_data  (data_s[i+1]),
                .dn_ready (ready_s[i+1]),
                .key_low  (key_low_reg),
                .key_high (key_high_reg)
            );

            assign stage_valid[i] = ctl_s[i+1].valid;
        end
    endgenerate

    assign rsp_valid = ctl_s[NSTAGE].valid;
    assign block_out = data_s[NSTAGE];

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> &stage_valid)
        else $error("request refused while a stage is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> stage_valid[0])
        else $error("accepted request did not enter the first stage");

    a_drain_opens_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> cmd_ready)
        else $error("input blocked while the output side is ready");

endmodule

// ===== sim/pipo64_128_block_cipher_unit_checker.sv =====
module pipo64_128_block_cipher_unit_checker #(
    parameter int ROUNDS = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  logic        opcode,
    input  logic [63:0] block_in,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [63:0] block_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0][2:0] ROT_AMOUNT = {3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0};

    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [7:0]  sbox_fwd [256];
    logic [7:0]  sbox_rev [256];
    logic [63:0] expected_blocks [$];
    logic [63:0] want;
    int          error_total;

    // One column of the bitsliced S-box: bit k of the argument is the bit of state byte k.
    function automatic logic [7:0] sbox_column(input logic [7:0] v);
        logic [7:0] s;
        logic       a;
        logic       b;
        logic       c;
        s = v;
        s[5] ^= s[7] & s[6];
        s[4] ^= s[3] & s[5];
        s[7] ^= s[4];
        s[6] ^= s[3];
        s[3] ^= s[4] | s[5];
        s[5] ^= s[7];
        s[4] ^= s[5] & s[6];
        s[2] ^= s[1] & s[0];
        s[0] ^= s[2] | s[1];
        s[1] ^= s[2] | s[0];
        s[2] = ~s[2];
        s[7] ^= s[1];
        s[3] ^= s[2];
        s[4] ^= s[0];
        a = s[7];
        b = s[3];
        c = s[4];
        s[6] ^= a & s[5];
        a ^= s[6];
        s[6] ^= c | b;
        b ^= s[5];
        s[5] ^= s[6] | c;
        c ^= b & a;
        s[2] ^= a;
        a = s[1] ^ c;
        s[1] = s[0] ^ b;
        s[0] = s[7];
        s[7] = a;
        b = s[3];
        s[3] = s[6];
        s[6] = b;
        c = s[4];
        s[4] = s[5];
        s[5] = c;
        return s;
    endfunction

    function automatic logic [63:0] substitute(input logic [63:0] blk, input logic inverse);
        logic [63:0] res;
        logic [7:0]  col;
        res = blk;
        for (int j = 0; j < 8; j++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                col[k] = blk[8 * k + j];
            end
            col = inverse ? sbox_rev[col] : sbox_fwd[col];
            for (int k = 0; k < 8; k++)
            begin
                res[8 * k + j] = col[k];
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] rotate_bytes(input logic [63:0] blk, input logic inverse);
        logic [63:0] res;
        logic [7:0]  b;
        logic [2:0]  n;
        for (int k = 0; k < 8; k++)
        begin
            b = blk[8 * k +: 8];
            n = inverse ? 3'(4'd8 - {1'b0, ROT_AMOUNT[k]}) : ROT_AMOUNT[k];
            res[8 * k +: 8] = (n == 3'd0) ? b : ((b << n) | (b >> (4'd8 - {1'b0, n})));
        end
        return res;
    endfunction

    function automatic logic [63:0] subkey(input int r);
        return (r[0] ? key_high : key_low) ^ 64'(r[7:0]);
    endfunction

    function automatic logic [63:0] pipo_block(input logic op, input logic [63:0] blk);
        logic [63:0] x;
        x = blk;
        if (op == pipo_pkg::OP_ENCRYPT)
        begin
            x ^= subkey(0);
            for (int r = 1; r <= ROUNDS; r++)
            begin
                x = rotate_bytes(substitute(x, 1'b0), 1'b0) ^ subkey(r);
            end
        end
        else
        begin
            for (int r = ROUNDS; r >= 1; r--)
            begin
                x = substitute(rotate_bytes(x ^ subkey(r), 1'b1), 1'b1);
            end
            x ^= subkey(0);
        end
        return x;
    endfunction

    initial
    begin
        for (int v = 0; v < 256; v++)
        begin
            sbox_fwd[v] = sbox_column(v[7:0]);
            sbox_rev[sbox_fwd[v]] = v[7:0];
        end
    end

    // A request taken at the same edge as a key write still sees the old key.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low = '0;
            key_high = '0;
            expected_blocks.delete();
            error_total = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                expected_blocks.push_back(pipo_block(opcode, block_in));
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    error_total++;
                    $display("%0t: unexpected response, expected none, actual %h",
                             $time, block_out);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (block_out !== want)
                    begin
                        error_total++;
                        $display("%0t: block_out mismatch, expected %h, actual %h",
                                 $time, want, block_out);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == pipo_pkg::CFG_KEY_LOW)
                begin
                    key_low = cfg_data;
                end
                else
                begin
                    key_high = cfg_data;
                end
            end
            fail_count <= error_total;
            outstanding <= expected_blocks.size();
        end
    end

endmodule

// ===== sim/pipo64_128_block_cipher_unit_tb.sv =====
module pipo64_128_block_cipher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ROUNDS = 13;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_PER_KEY = 120;
    localparam logic [63:0] ALL_ONES = '1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic        opcode = pipo_pkg::OP_ENCRYPT;
    logic [63:0] block_in = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [63:0] block_out;
    logic        cfg_we = 1'b0;
    logic        cfg_index = pipo_pkg::CFG_KEY_LOW;
    logic [63:0] cfg_data = '0;

    int fail_count;
    int outstanding;
    int send_gap_pct = 6;
    int rsp_stall_pct = 78;
    int quiet_cycles = 0;

    pipo64_128_block_cipher_unit #(
        .ROUNDS(ROUNDS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .opcode(opcode),
        .block_in(block_in),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .block_out(block_out),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    pipo64_128_block_cipher_unit_checker #(
        .ROUNDS(ROUNDS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .opcode(opcode),
        .block_in(block_in),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .block_out(block_out),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pipo64_128_block_cipher_unit_tb: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Returns in the time step of the edge that took the request, with cmd_valid still high.
    task automatic send_request(input logic op, input logic [63:0] blk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        opcode <= op;
        block_in <= blk;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_both_ops(input logic [63:0] blk);
        send_request(pipo_pkg::OP_ENCRYPT, blk);
        send_request(pipo_pkg::OP_DECRYPT, blk);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    task automatic set_keys(input logic [63:0] kl, input logic [63:0] kh);
        cfg_we <= 1'b1;
        cfg_index <= pipo_pkg::CFG_KEY_LOW;
        cfg_data <= kl;
        @(posedge clk);
        cfg_index <= pipo_pkg::CFG_KEY_HIGH;
        cfg_data <= kh;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_request();
        logic [63:0] blk;
        case ($urandom_range(7))
            0: blk = 64'h1 << $urandom_range(63);
            1: blk = ~(64'h1 << $urandom_range(63));
            2: blk = {32'h0, $urandom()};
            default: blk = {$urandom(), $urandom()};
        endcase
        send_request(($urandom_range(1) == 0) ? pipo_pkg::OP_ENCRYPT : pipo_pkg::OP_DECRYPT,
                     blk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the all-zero key left by reset.
        send_both_ops(64'h0);
        send_both_ops(ALL_ONES);
        send_both_ops(64'h1);
        send_both_ops(64'h8000_0000_0000_0000);
        send_both_ops(64'h5555_5555_5555_5555);
        send_both_ops(64'hAAAA_AAAA_AAAA_AAAA);
        send_both_ops(64'h00FF_00FF_00FF_00FF);
        send_both_ops(64'h0123_4567_89AB_CDEF);
        wait_drained();
        set_keys(ALL_ONES, ALL_ONES);
        send_both_ops(64'h0);
        send_both_ops(ALL_ONES);

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_gap_pct = 6;
                    rsp_stall_pct = 78;
                end
                1:
                begin
                    send_gap_pct = 78;
                    rsp_stall_pct = 6;
                end
                default:
                begin
                    send_gap_pct = 0;
                    rsp_stall_pct = 0;
                end
            endcase
            for (int s = 0; s < 4; s++)
            begin
                wait_drained();
                case (s)
                    0: set_keys(64'h0, ALL_ONES);
                    1: set_keys(ALL_ONES, 64'h0);
                    default: set_keys({$urandom(), $urandom()}, {$urandom(), $urandom()});
                endcase
                for (int i = 0; i < RANDOM_PER_KEY; i++)
                begin
                    send_random_request();
                    if ($urandom_range(199) == 0)
                    begin
                        wait_drained();
                    end
                end
            end
        end

        wait_drained();
        repeat (ROUNDS + 6) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("pipo64_128_block_cipher_unit_tb: clean");
        end
        else
        begin
            $display("pipo64_128_block_cipher_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pipo_pkg.sv
rtl/core/pipo_stage.sv
rtl/core/pipo64_128_block_cipher_unit.sv
sim/pipo64_128_block_cipher_unit_checker.sv
sim/pipo64_128_block_cipher_unit_tb.sv
